/* rtl/core/pdc_pkg.sv */
// Shared types, constants and CRC helpers for the packet deframer.
package pdc_pkg;

	localparam logic [7:0] POLY_RESET = 8'h07;

	localparam int unsigned SWEEP_W = 6;
	localparam logic [SWEEP_W-1:0] SWEEP_LAST = 6'd63;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned PTR_W = 1;
	localparam int unsigned CNT_W = 2;

	localparam logic [6:0] POS_MARKER = 7'd0;
	localparam logic [6:0] POS_HDR1 = 7'd1;
	localparam logic [6:0] POS_HDR2 = 7'd2;
	localparam logic [6:0] POS_BODY = 7'd3;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// t_col: image of each CRC bit after one byte; u_col[j]: image of data bit j
	typedef struct packed {
		logic [7:0][7:0] t_col;
		logic [7:0][7:0] u_col;
		logic            rdy;
	} crc_tbl_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		logic [7:0] marker;
		logic [5:0] length;
		logic [4:0] sequence_number;
		logic [4:0] frame_type;
		logic       crc_ok;
		logic       last;
	} result_t;

	function automatic logic [7:0] lfsr_step(logic [7:0] v, logic [7:0] poly);
		return {v[6:0], 1'b0} ^ (v[7] ? poly : 8'h00);
	endfunction

	function automatic logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] b, crc_tbl_t tbl);
		logic [7:0] r;
		r = 8'h00;
		for (int j = 0; j < 8; j++) begin
			if (crc[j])
				r = r ^ tbl.t_col[j];
			if (b[j])
				r = r ^ tbl.u_col[j];
		end
		return r;
	endfunction

endpackage

/* rtl/core/pdc_if.sv */
// Valid/ready channel interfaces for the deframer input and result streams.
interface pdc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source(output valid, data_byte, frame_start, input ready);
	modport sink(input valid, data_byte, frame_start, output ready);
endinterface

interface pdc_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] payload_byte;
	logic [7:0] marker;
	logic [5:0] length;
	logic [4:0] sequence_number;
	logic [4:0] frame_type;
	logic       crc_ok;
	logic       last;

	modport source(output valid, kind, payload_byte, marker, length, sequence_number,
		frame_type, crc_ok, last, input ready);
	modport sink(input valid, kind, payload_byte, marker, length, sequence_number,
		frame_type, crc_ok, last, output ready);
endinterface

/* rtl/core/packet_deframer_crc_check_unit.sv */
// Top level: packet deframer with CRC-8 check.
// Throughput: one byte per cycle while the queue has room and the matrix is ready;
// the CRC update is a single 8x8 GF(2) matrix step. A result is written into the
// queue when its byte transfers. Reset and every polynomial write start a sweep
// that builds the CRC matrix; the input is not ready during it. Config writes are
// taken anytime. Reset clears parser state, queue and sets the polynomial to 0x07.
module packet_deframer_crc_check_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	pdc_in_if.sink     in_ch,
	pdc_out_if.source  out_ch
);

	pdc_pkg::crc_tbl_t tbl;
	pdc_pkg::result_t  push_data;
	logic              push;
	logic              full;

	pdc_crc_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.tbl       (tbl)
	);

	pdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.tbl       (tbl),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	pdc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.out_ch    (out_ch)
	);

endmodule

/* rtl/core/pdc_crc_table.sv */
// Polynomial register and sweep that builds the per-byte CRC update matrix.
module pdc_crc_table (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	output pdc_pkg::crc_tbl_t tbl
);

	logic [7:0]                   poly_q;
	logic [7:0][7:0]              col_q;
	logic [7:0][7:0]              u_q;
	logic [pdc_pkg::SWEEP_W-1:0]  cnt_q;
	logic                         busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= pdc_pkg::POLY_RESET;
			busy_q <= 1'b1;
			cnt_q  <= '0;
			for (int j = 0; j < 8; j++)
				col_q[j] <= 8'(1 << j);
		end else if (cfg_we) begin
			poly_q <= cfg_wdata;
			busy_q <= 1'b1;
			cnt_q  <= '0;
			for (int j = 0; j < 8; j++)
				col_q[j] <= 8'(1 << j);
		end else if (busy_q) begin
			for (int j = 0; j < 8; j++)
				col_q[j] <= pdc_pkg::lfsr_step(col_q[j], poly_q);
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == pdc_pkg::SWEEP_LAST)
				busy_q <= 1'b0;
		end
	end

	// every eighth shift, column 0 holds the next power of the bit map applied to bit 0
	always_ff @(posedge clk) begin
		if (busy_q && !cfg_we && (cnt_q[2:0] == 3'd7))
			u_q[cnt_q[5:3]] <= pdc_pkg::lfsr_step(col_q[0], poly_q);
	end

	assign tbl.t_col = col_q;
	assign tbl.u_col = u_q;
	assign tbl.rdy   = !busy_q;

endmodule

/* rtl/core/pdc_front.sv */
// Frame parser: tracks position, header fields and CRC, emits results.
module pdc_front (
	input  logic              clk,
	input  logic              arst_n,
	pdc_in_if.sink            in_ch,
	input  pdc_pkg::crc_tbl_t tbl,
	input  logic              full,
	output logic              push,
	output pdc_pkg::result_t  push_data
);

	logic [6:0] pos_q;
	logic       in_frame_q;
	logic [7:0] marker_q;
	logic [5:0] length_q;
	logic [4:0] seq_q;
	logic [4:0] type_q;
	logic [7:0] crc_q;

	logic [6:0] pos_d;
	logic       in_frame_d;
	logic [7:0] marker_d;
	logic [5:0] length_d;
	logic [4:0] seq_d;
	logic [4:0] type_d;
	logic [7:0] crc_d;
	logic [6:0] end_pos;
	logic [7:0] crc_next;
	logic       acc;
	logic [7:0] b;

	assign in_ch.ready = !full && tbl.rdy;
	assign acc         = in_ch.valid && in_ch.ready;
	assign b           = in_ch.data_byte;
	assign end_pos     = {1'b0, length_q} + pdc_pkg::POS_BODY;
	assign crc_next    = pdc_pkg::crc_byte(crc_q, b, tbl);

	always_comb begin
		pos_d      = pos_q;
		in_frame_d = in_frame_q;
		marker_d   = marker_q;
		length_d   = length_q;
		seq_d      = seq_q;
		type_d     = type_q;
		crc_d      = crc_q;
		push       = 1'b0;
		push_data.kind            = pdc_pkg::KIND_PAYLOAD;
		push_data.payload_byte    = b;
		push_data.marker          = marker_q;
		push_data.length          = length_q;
		push_data.sequence_number = seq_q;
		push_data.frame_type      = type_q;
		push_data.crc_ok          = 1'b0;
		push_data.last            = 1'b0;
		if (acc) begin
			if (in_ch.frame_start) begin
				marker_d   = b;
				length_d   = '0;
				seq_d      = '0;
				type_d     = '0;
				crc_d      = '0;
				pos_d      = pdc_pkg::POS_HDR1;
				in_frame_d = 1'b1;
			end else if (in_frame_q) begin
				if (pos_q == pdc_pkg::POS_HDR1) begin
					length_d = b[7:2];
					seq_d    = {b[1:0], 3'b000};
					crc_d    = crc_next;
					pos_d    = pdc_pkg::POS_HDR2;
				end else if (pos_q == pdc_pkg::POS_HDR2) begin
					seq_d  = {seq_q[4:3], b[7:5]};
					type_d = b[4:0];
					crc_d  = crc_next;
					pos_d  = pdc_pkg::POS_BODY;
				end else if (pos_q < end_pos) begin
					crc_d = crc_next;
					pos_d = pos_q + 7'd1;
					push  = 1'b1;
				end else begin
					push                   = 1'b1;
					push_data.kind         = pdc_pkg::KIND_SUMMARY;
					push_data.payload_byte = 8'h00;
					push_data.crc_ok       = (b == crc_q);
					push_data.last         = 1'b1;
					in_frame_d             = 1'b0;
					pos_d                  = pdc_pkg::POS_MARKER;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= pdc_pkg::POS_MARKER;
			in_frame_q <= 1'b0;
			marker_q   <= '0;
			length_q   <= '0;
			seq_q      <= '0;
			type_q     <= '0;
			crc_q      <= '0;
		end else begin
			pos_q      <= pos_d;
			in_frame_q <= in_frame_d;
			marker_q   <= marker_d;
			length_q   <= length_d;
			seq_q      <= seq_d;
			type_q     <= type_d;
			crc_q      <= crc_d;
		end
	end

endmodule

/* rtl/core/pdc_queue.sv */
// Two-entry result queue that drives the output channel.
module pdc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pdc_pkg::result_t push_data,
	output logic             full,
	pdc_out_if.source        out_ch
);

	pdc_pkg::result_t              mem_q [pdc_pkg::QUEUE_DEPTH];
	logic [pdc_pkg::PTR_W-1:0]     wr_q;
	logic [pdc_pkg::PTR_W-1:0]     rd_q;
	logic [pdc_pkg::CNT_W-1:0]     cnt_q;
	logic                          pop;
	pdc_pkg::result_t              head;

	assign full   = (cnt_q == pdc_pkg::CNT_W'(pdc_pkg::QUEUE_DEPTH));
	assign pop    = out_ch.valid && out_ch.ready;
	assign head   = mem_q[rd_q];

	assign out_ch.valid           = (cnt_q != '0);
	assign out_ch.kind            = head.kind;
	assign out_ch.payload_byte    = head.payload_byte;
	assign out_ch.marker          = head.marker;
	assign out_ch.length          = head.length;
	assign out_ch.sequence_number = head.sequence_number;
	assign out_ch.frame_type      = head.frame_type;
	assign out_ch.crc_ok          = head.crc_ok;
	assign out_ch.last            = head.last;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* rtl/core/pdc_chk.sv */
// Port-level checker for the deframer, bound to the top level.
module pdc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_kind,
	input logic [7:0] out_payload_byte,
	input logic       out_crc_ok,
	input logic       out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind)
			&& $stable(out_payload_byte) && $stable(out_crc_ok))
		else $error("result changed while stalled");

	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == pdc_pkg::KIND_PAYLOAD) |-> !out_crc_ok && !out_last)
		else $error("payload result carries summary flags");

	a_summary_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == pdc_pkg::KIND_SUMMARY) |-> (out_payload_byte == 8'h00)
			&& out_last)
		else $error("summary result malformed");

	a_cfg_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("input ready during CRC matrix sweep");

endmodule

bind packet_deframer_crc_check_unit pdc_chk u_pdc_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.cfg_we           (cfg_we),
	.in_ready         (in_ch.ready),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_kind         (out_ch.kind),
	.out_payload_byte (out_ch.payload_byte),
	.out_crc_ok       (out_ch.crc_ok),
	.out_last         (out_ch.last)
);

/* dv/tb.sv */
// Testbench for the packet deframer: directed table, then random frames under several polynomials.
`timescale 1ns / 1ps

module tb;
	import pdc_pkg::*;

	localparam result_t NO_RES = '0;
	localparam int PHASE_ITEMS = 72;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       typed;
		result_t    want;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	pdc_in_if  in_ch();
	pdc_out_if out_ch();

	packet_deframer_crc_check_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// deframer state as seen from outside
	logic [7:0] poly;
	logic [6:0] pos;
	logic       in_frm;
	logic [7:0] hold_mk;
	logic [5:0] hold_len;
	logic [4:0] hold_seq;
	logic [4:0] hold_typ;
	logic [7:0] crc_acc;

	result_t due_results[$];
	int      errors;
	int      items_in;
	int      tx_calm;
	int      rx_calm;

	// directed frames: idle byte, zero length good/bad CRC, extremes, restart
	dir_row_t dir_tab [25] = '{
		'{8'h3C, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b1, {KIND_SUMMARY, 8'h00, 8'hFF, 6'd0, 5'd0, 5'd0, 1'b1, 1'b1}},
		'{8'h55, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b1, {KIND_SUMMARY, 8'h00, 8'h00, 6'd0, 5'd0, 5'd0, 1'b0, 1'b1}},
		'{8'hA5, 1'b1, 1'b0, NO_RES},
		'{8'h0B, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b1, {KIND_PAYLOAD, 8'h00, 8'hA5, 6'd2, 5'd31, 5'd31, 1'b0, 1'b0}},
		'{8'hFF, 1'b0, 1'b1, {KIND_PAYLOAD, 8'hFF, 8'hA5, 6'd2, 5'd31, 5'd31, 1'b0, 1'b0}},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h81, 1'b1, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, NO_RES},
		'{8'h1F, 1'b0, 1'b0, NO_RES},
		'{8'h42, 1'b0, 1'b1, {KIND_PAYLOAD, 8'h42, 8'h81, 6'd63, 5'd24, 5'd31, 1'b0, 1'b0}},
		'{8'h7E, 1'b1, 1'b0, NO_RES},
		'{8'h04, 1'b0, 1'b0, NO_RES},
		'{8'hE0, 1'b0, 1'b0, NO_RES},
		'{8'h99, 1'b0, 1'b0, NO_RES},
		'{8'h12, 1'b0, 1'b0, NO_RES}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// bit-serial CRC: xor bit into LSB, then eight feedback shifts
	function automatic logic [7:0] crc_feed(logic [7:0] crc, logic [7:0] b, logic [7:0] p);
		for (int i = 7; i >= 0; i--) begin
			crc[0] = crc[0] ^ b[i];
			for (int k = 0; k < 8; k++)
				crc = crc[7] ? ({crc[6:0], 1'b0} ^ p) : {crc[6:0], 1'b0};
		end
		return crc;
	endfunction

	task automatic deframe_byte(input logic [7:0] b, input logic s, output bit emit,
		output result_t r);
		emit = 1'b0;
		r = NO_RES;
		if (s) begin
			hold_mk = b;
			hold_len = '0;
			hold_seq = '0;
			hold_typ = '0;
			crc_acc = '0;
			pos = POS_HDR1;
			in_frm = 1'b1;
		end else if (in_frm) begin
			if (pos == POS_HDR1) begin
				hold_len = b[7:2];
				hold_seq = {b[1:0], 3'b000};
				crc_acc = crc_feed(crc_acc, b, poly);
				pos = POS_HDR2;
			end else if (pos == POS_HDR2) begin
				hold_seq[2:0] = b[7:5];
				hold_typ = b[4:0];
				crc_acc = crc_feed(crc_acc, b, poly);
				pos = POS_BODY;
			end else if (int'(pos) < int'(hold_len) + 3) begin
				crc_acc = crc_feed(crc_acc, b, poly);
				pos = pos + 7'd1;
				emit = 1'b1;
				r = {KIND_PAYLOAD, b, hold_mk, hold_len, hold_seq, hold_typ, 1'b0, 1'b0};
			end else begin
				emit = 1'b1;
				r = {KIND_SUMMARY, 8'h00, hold_mk, hold_len, hold_seq, hold_typ,
					b == crc_acc, 1'b1};
				in_frm = 1'b0;
				pos = POS_MARKER;
			end
		end
	endtask

	task automatic report(string msg);
		errors++;
		if (errors <= 30)
			$display("mismatch: %s", msg);
	endtask

	task automatic cmp_field(string nm, int got, int want);
		if (got != want)
			report($sformatf("%s got %0h want %0h", nm, got, want));
	endtask

	task automatic check_result(result_t got);
		result_t want;
		if (due_results.size() == 0) begin
			report($sformatf("result %h with none due", got));
			return;
		end
		want = due_results.pop_front();
		cmp_field("kind", got.kind, want.kind);
		cmp_field("payload_byte", got.payload_byte, want.payload_byte);
		cmp_field("marker", got.marker, want.marker);
		cmp_field("length", got.length, want.length);
		cmp_field("sequence_number", got.sequence_number, want.sequence_number);
		cmp_field("frame_type", got.frame_type, want.frame_type);
		cmp_field("crc_ok", got.crc_ok, want.crc_ok);
		cmp_field("last", got.last, want.last);
	endtask

	// mostly short gaps, a few long ones, and calm stretches with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// offer one byte and wait for its transfer; returns the predicted result
	task automatic push_byte(input logic [7:0] d, input logic s, output bit emit,
		output result_t r);
		int gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= d;
		in_ch.frame_start <= s;
		do
			@(posedge clk);
		while (!in_ch.ready);
		items_in++;
		deframe_byte(d, s, emit, r);
	endtask

	task automatic send(input logic [7:0] d, input logic s);
		bit      emit;
		result_t r;
		push_byte(d, s, emit, r);
		if (emit)
			due_results.push_back(r);
	endtask

	task automatic drain;
		in_ch.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_poly(input logic [7:0] p);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we <= 1'b0;
		poly = p;
	endtask

	// one frame, sometimes cut short or followed by bytes the block ignores
	task automatic send_frame(inout int sent);
		logic [7:0] fb[$];
		logic [5:0] len;
		logic [4:0] sq;
		logic [7:0] crc;
		int         n;
		int         r;
		r = $urandom_range(0, 99);
		if (r < 10)
			len = 6'($urandom_range(32, 63));
		else if (r < 20)
			len = 6'($urandom_range(7, 31));
		else
			len = 6'($urandom_range(0, 6));
		sq = 5'($urandom_range(0, 31));
		fb.push_back(8'($urandom_range(0, 255)));
		fb.push_back({len, sq[4:3]});
		fb.push_back({sq[2:0], 5'($urandom_range(0, 31))});
		for (int i = 0; i < len; i++)
			fb.push_back(8'($urandom_range(0, 255)));
		crc = 8'h00;
		for (int i = 1; i < fb.size(); i++)
			crc = crc_feed(crc, fb[i], poly);
		fb.push_back(($urandom_range(0, 9) < 7) ? crc : 8'($urandom_range(0, 255)));
		n = fb.size();
		if ($urandom_range(0, 9) == 0)
			n = $urandom_range(1, fb.size() - 1);
		for (int i = 0; i < n; i++) begin
			send(fb[i], i == 0);
			sent++;
		end
		if (n == fb.size() && $urandom_range(0, 6) == 0)
			repeat ($urandom_range(1, 3)) send(8'($urandom_range(0, 255)), 1'b0);
	endtask

	initial begin
		bit      emit;
		result_t r;
		int      sent;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 8'h00;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= 8'h00;
		in_ch.frame_start <= 1'b0;
		poly = POLY_RESET;
		pos = POS_MARKER;
		in_frm = 1'b0;
		hold_mk = '0;
		hold_len = '0;
		hold_seq = '0;
		hold_typ = '0;
		crc_acc = '0;
		errors = 0;
		items_in = 0;
		tx_calm = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			push_byte(dir_tab[i].data, dir_tab[i].start, emit, r);
			if (dir_tab[i].typed)
				due_results.push_back(dir_tab[i].want);
			else if (emit)
				due_results.push_back(r);
		end

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: set_poly(8'h00);
				2: set_poly(8'hFF);
				3, 4: set_poly(8'($urandom_range(0, 255)));
				default: ;
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 11) == 0)
					send(8'($urandom_range(0, 255)), 1'b0);
				else
					send_frame(sent);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && due_results.size() == 0)
			$display("TB_OK");
		else begin
			if (due_results.size() != 0)
				report($sformatf("%0d results never arrived", due_results.size()));
			$display("TB_ERROR");
		end
		$finish;
	end

	// result sink: random stalls plus one long hold-off to back the block up
	initial begin
		int  rx_idle;
		int  hold_left;
		bit  hold_done;
		rx_idle = 0;
		hold_left = 0;
		hold_done = 1'b0;
		rx_calm = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				check_result({out_ch.kind, out_ch.payload_byte, out_ch.marker, out_ch.length,
					out_ch.sequence_number, out_ch.frame_type, out_ch.crc_ok,
					out_ch.last});
			if (!hold_done && items_in >= 200) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (rx_idle > 0) begin
				rx_idle--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				rx_idle = pick_gap(rx_calm);
			end
		end
	end

endmodule
